FILE: design/csv_row_field_splitter_macros.svh
// assertion helpers used by the splitter back end
`ifndef CSV_ROW_FIELD_SPLITTER_MACROS_SVH
`define CSV_ROW_FIELD_SPLITTER_MACROS_SVH

// same-cycle implication, muted while reset is high
`define CSVRFS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csvrfs assertion failed");

// next-cycle implication, muted while reset is high
`define CSVRFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csvrfs assertion failed");

`endif

FILE: design/csvrfs_pkg.sv
package csvrfs_pkg;

   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [7:0] SPACE_CHAR   = 8'd32;
   localparam logic [7:0] TAB_CHAR     = 8'd9;
   localparam logic [7:0] CR_CHAR      = 8'd13;

   localparam logic [7:0] DELIMITER_RESET      = 8'd44;
   localparam logic [7:0] QUOTE_RESET          = 8'd34;
   localparam logic [7:0] COMMENT_RESET        = 8'd35;
   localparam logic       HEADER_PRESENT_RESET = 1'b1;
   localparam logic       HEADER_SKIP_RESET    = 1'b0;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMENT        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_PRESENT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SKIP    = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef enum logic [1:0] {
      CMD_NOP  = 2'd0,
      CMD_HOLD = 2'd1,
      CMD_DATA = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0]   data;
      cmd_kind_type kind;
      logic         close;
      logic         clear;
   } cmd_type;

   typedef struct packed {
      logic [7:0] delimiter_char;
      logic [7:0] quote_char;
      logic [7:0] comment_char;
      logic       header_present;
      logic       header_skip;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       field_done;
      logic       row_done;
      logic       space_overflow;
   } result_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
   endfunction

endpackage

FILE: design/csvrfs_req_if.sv
interface csvrfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       stream_last;

   modport source (output valid, output text_byte, output stream_last, input ready);
   modport sink   (input valid, input text_byte, input stream_last, output ready);
endinterface

FILE: design/csvrfs_rsp_if.sv
interface csvrfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_present;
   logic       field_done;
   logic       row_done;
   logic       space_overflow;

   modport source (output valid, output out_byte, output byte_present, output field_done,
                   output row_done, output space_overflow, input ready);
   modport sink   (input valid, input out_byte, input byte_present, input field_done,
                   input row_done, input space_overflow, output ready);
endinterface

FILE: design/csvrfs_front.sv
module csvrfs_front
   import csvrfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   csvrfs_req_if.sink   req_ch,
   input  logic         queue_full,
   output logic         cmd_push,
   output cmd_type      cmd
);

   typedef enum logic [3:0] {
      PH_START   = 4'b0001,
      PH_PENDING = 4'b0010,
      PH_DATA    = 4'b0100,
      PH_SKIP    = 4'b1000
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      seen_ff, seen_in;
   logic      accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign cmd_push     = accept && ((cmd.kind != CMD_NOP) || cmd.close || cmd.clear);

   always_comb begin
      cmd.data  = req_ch.text_byte;
      cmd.kind  = CMD_NOP;
      cmd.close = 1'b0;
      cmd.clear = 1'b0;
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      if (req_ch.text_byte == NEWLINE_CHAR) begin
         cmd.close = (phase_ff == PH_DATA);
         cmd.clear = 1'b1;
         phase_in  = PH_START;
      end else begin
         if (phase_ff != PH_SKIP) begin
            if ((phase_ff == PH_START) && (req_ch.text_byte == cfg.comment_char)) begin
               phase_in = PH_SKIP;
            end else if (is_space(req_ch.text_byte)) begin
               if (phase_ff == PH_START) begin
                  phase_in = PH_PENDING;
               end
               cmd.kind = CMD_HOLD;
            end else if (phase_ff != PH_DATA) begin
               // first real byte of the line, maybe the header
               seen_in = 1'b1;
               if (cfg.header_present && cfg.header_skip && !seen_ff) begin
                  phase_in  = PH_SKIP;
                  cmd.clear = 1'b1;
               end else begin
                  phase_in = PH_DATA;
                  cmd.kind = CMD_DATA;
               end
            end else begin
               cmd.kind = CMD_DATA;
            end
         end
         if (req_ch.stream_last) begin
            cmd.close = (phase_in == PH_DATA);
            cmd.clear = 1'b1;
            phase_in  = PH_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         seen_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

FILE: design/csvrfs_queue.sv
module csvrfs_queue
   import csvrfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_data
);

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/csvrfs_back.sv
`include "csv_row_field_splitter_macros.svh"

module csvrfs_back
   import csvrfs_pkg::*;
#(
   parameter int HELD_SPACE_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   csvrfs_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(HELD_SPACE_DEPTH + 1);
   localparam int IDX_W = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REPLAY = 5'b00010,
      ST_BYTE   = 5'b00100,
      ST_CLOSE  = 5'b01000,
      ST_DRAIN  = 5'b10000
   } state_type;

   typedef struct packed {
      logic       valid;
      logic       is_end;
      logic       row;
      logic [7:0] data;
      logic       mark;
   } op_type;

   typedef struct packed {
      logic       push;
      result_type push_res;
      logic       pend_valid;
      result_type pend_res;
   } apply_type;

   // one result op against the held-back result: merges a field end onto a bare byte
   function automatic apply_type apply_op(input logic pv, input result_type pend,
                                          input op_type op);
      apply_type r;
      r.push       = 1'b0;
      r.push_res   = pend;
      r.pend_valid = pv;
      r.pend_res   = pend;
      if (op.valid) begin
         if (!op.is_end) begin
            r.push                    = pv;
            r.pend_valid              = 1'b1;
            r.pend_res.out_byte       = op.data;
            r.pend_res.byte_present   = 1'b1;
            r.pend_res.field_done     = 1'b0;
            r.pend_res.row_done       = 1'b0;
            r.pend_res.space_overflow = op.mark;
         end else if (pv && pend.byte_present && !pend.field_done) begin
            r.pend_res.field_done = 1'b1;
            r.pend_res.row_done   = op.row;
         end else begin
            r.push                    = pv;
            r.pend_valid              = 1'b1;
            r.pend_res.out_byte       = '0;
            r.pend_res.byte_present   = 1'b0;
            r.pend_res.field_done     = 1'b1;
            r.pend_res.row_done       = op.row;
            r.pend_res.space_overflow = op.mark;
         end
      end
      return r;
   endfunction

   state_type  state_ff, state_in;
   cmd_type    cur_ff, cur_in;
   logic       quotes_ff, quotes_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic       ovf_ff, ovf_in;
   logic       mark_ff, mark_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic       pend_valid_ff, pend_valid_in;
   result_type pend_ff, pend_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic [7:0] rd_ff;
   logic [7:0] held_mem [HELD_SPACE_DEPTH];

   logic             out_free;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic             op_active;
   logic             last_op;
   logic             use_act;
   logic             toggle;
   logic [7:0]       src;
   logic             q_eff;
   logic             mark_now;
   logic             clear_now;
   op_type           op;
   apply_type        app;

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign mem_waddr = count_ff[IDX_W-1:0];

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.out_byte       = out_ff.out_byte;
   assign rsp_ch.byte_present   = out_ff.byte_present;
   assign rsp_ch.field_done     = out_ff.field_done;
   assign rsp_ch.row_done       = out_ff.row_done;
   assign rsp_ch.space_overflow = out_ff.space_overflow;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      quotes_in     = quotes_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      mark_in       = mark_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_in        = out_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = idx_ff[IDX_W-1:0];
      op            = '0;
      op_active     = 1'b0;
      last_op       = 1'b0;
      use_act       = 1'b0;
      toggle        = 1'b0;
      src           = '0;
      q_eff         = quotes_ff;
      mark_now      = mark_ff;
      clear_now     = cur_ff.clear;

      unique case (state_ff)
         ST_IDLE: begin
            // fast path: data byte with nothing held
            src       = cmd.data;
            mark_now  = ovf_ff;
            use_act   = 1'b1;
            last_op   = !cmd.close;
            clear_now = cmd.clear;
            rd_addr   = '0;
            op_active = cmd_valid && (cmd.kind == CMD_DATA) && (count_ff == '0) && out_free;
         end
         ST_REPLAY: begin
            src       = rd_ff;
            use_act   = 1'b1;
            op_active = out_free;
         end
         ST_BYTE: begin
            src       = cur_ff.data;
            use_act   = 1'b1;
            last_op   = !cur_ff.close;
            op_active = out_free;
         end
         ST_CLOSE: begin
            op.valid  = 1'b1;
            op.is_end = 1'b1;
            op.row    = 1'b1;
            op.mark   = mark_ff;
            last_op   = 1'b1;
            op_active = out_free;
         end
         ST_DRAIN: begin
         end
         default: begin
         end
      endcase

      // quote wins over delimiter
      if (use_act) begin
         if (src == cfg.quote_char) begin
            toggle = 1'b1;
         end else if ((src == cfg.delimiter_char) && !q_eff) begin
            op.valid  = 1'b1;
            op.is_end = 1'b1;
            op.row    = 1'b0;
            op.mark   = mark_now;
         end else begin
            op.valid = 1'b1;
            op.data  = src;
            op.mark  = mark_now;
         end
      end

      app = apply_op(pend_valid_ff, pend_ff, op);

      if (op_active) begin
         if (toggle) begin
            quotes_in = !quotes_ff;
         end
         if (state_ff == ST_IDLE) begin
            cmd_pop = 1'b1;
         end
         if (last_op) begin
            count_in = '0;
            ovf_in   = 1'b0;
            if (clear_now) begin
               quotes_in = 1'b0;
            end
            if (app.push || app.pend_valid) begin
               out_valid_in = 1'b1;
               out_in       = app.push ? app.push_res : app.pend_res;
            end
            if (app.push && app.pend_valid) begin
               pend_valid_in = 1'b1;
               pend_in       = app.pend_res;
               state_in      = ST_DRAIN;
            end else begin
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end else begin
            if (app.push) begin
               out_valid_in = 1'b1;
               out_in       = app.push_res;
            end
            pend_valid_in = app.pend_valid;
            pend_in       = app.pend_res;
            if (state_ff == ST_IDLE) begin
               cur_in   = cmd;
               mark_in  = ovf_ff;
               state_in = ST_CLOSE;
            end else if (state_ff == ST_REPLAY) begin
               idx_in  = idx_ff + CNT_W'(1);
               rd_addr = idx_in[IDX_W-1:0];
               if (idx_in == count_ff) begin
                  state_in = ST_BYTE;
               end
            end else begin
               state_in = ST_CLOSE;
            end
         end
      end else if ((state_ff == ST_IDLE) && cmd_valid &&
                   !((cmd.kind == CMD_DATA) && (count_ff == '0))) begin
         cmd_pop = 1'b1;
         cur_in  = cmd;
         if (cmd.kind == CMD_DATA) begin
            // held whitespace first, oldest entry already being read
            mark_in  = ovf_ff;
            idx_in   = '0;
            state_in = ST_REPLAY;
         end else begin
            if (cmd.kind == CMD_HOLD) begin
               if (count_ff < CNT_W'(HELD_SPACE_DEPTH)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            mark_in = 1'b0;
            if (cmd.close) begin
               state_in = ST_CLOSE;
            end else if (cmd.clear) begin
               count_in  = '0;
               ovf_in    = 1'b0;
               quotes_in = 1'b0;
            end
         end
      end else if ((state_ff == ST_DRAIN) && out_free) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         pend_valid_in = 1'b0;
         state_in      = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         quotes_ff     <= 1'b0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         quotes_ff     <= quotes_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      mark_ff <= mark_in;
      idx_ff  <= idx_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         held_mem[mem_waddr] <= cmd.data;
      end
      rd_ff <= held_mem[rd_addr];
   end

   `CSVRFS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(HELD_SPACE_DEPTH))
   `CSVRFS_ASSERT_IMP(a_replay_in_range, clock, reset, state_ff == ST_REPLAY, idx_ff < count_ff)
   `CSVRFS_ASSERT_IMP(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff)
   `CSVRFS_ASSERT_NEXT(a_drain_done, clock, reset, (state_ff == ST_DRAIN) && out_free, (state_ff == ST_IDLE) && !pend_valid_ff)

endmodule

FILE: design/csv_row_field_splitter.sv
// csv row and field splitter: takes csv text one byte per req transaction and returns one rsp
// transaction per field data byte, with field_done and row_done riding on the last byte of a
// field where they can (a field end with no byte before it in the same input byte travels alone).
// trailing whitespace on a line is trimmed, blank and comment lines vanish, and with
// header_present and header_skip set the first real line is dropped. the front end tracks line
// state and queues up to four commands; the back end owns quote state and the held-whitespace
// buffer. rate: one input byte per cycle while the back end keeps up. a data byte that follows
// held whitespace bytes is worked off in back-end steps: a start of the read of the
// held-whitespace memory, a replay of each held byte through its single read port, then the
// byte itself; a row close adds a close step, and an input byte that yields two results takes
// a drain step for the second. configuration is taken through
// csr_wr_en / csr_index / csr_wdata and must only change while the block is idle
module csv_row_field_splitter
   import csvrfs_pkg::*;
#(
   parameter int HELD_SPACE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   csvrfs_req_if.sink             req_ch,
   csvrfs_rsp_if.source           rsp_ch
);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // front to queue
   logic    front_push;
   cmd_type front_cmd;
   logic    queue_full;

   // queue to back
   logic    back_pop;
   logic    queue_valid;
   cmd_type queue_cmd;

   // register write decode, unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DELIMITER:      cfg_in.delimiter_char = csr_wdata;
            CSR_QUOTE:          cfg_in.quote_char     = csr_wdata;
            CSR_COMMENT:        cfg_in.comment_char   = csr_wdata;
            CSR_HEADER_PRESENT: cfg_in.header_present = csr_wdata[0];
            CSR_HEADER_SKIP:    cfg_in.header_skip    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter_char <= DELIMITER_RESET;
         cfg_ff.quote_char     <= QUOTE_RESET;
         cfg_ff.comment_char   <= COMMENT_RESET;
         cfg_ff.header_present <= HEADER_PRESENT_RESET;
         cfg_ff.header_skip    <= HEADER_SKIP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // line classification: one command per input byte that matters
   csvrfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .cmd_push   (front_push),
      .cmd        (front_cmd)
   );

   // short command queue decoupling intake from the replay work
   csvrfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_cmd)
   );

   // quote handling, whitespace replay, field/row ends and the output register
   csvrfs_back #(
      .HELD_SPACE_DEPTH (HELD_SPACE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (back_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
